FILE: rtl/core/mbws_pkg.sv
// Package for the motif best-window scorer: beat payload types, register
// indexes and the per-position IUPAC scoring function.
// No dependencies.
package mbws_pkg;

    // Window storage depth and lane count; the 32-bit window field holds 16 bases.
    localparam int WIN_DEPTH = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_MOTIF_CODES  = 2'd0;
    localparam logic [1:0] REG_MOTIF_LENGTH = 2'd1;

    localparam logic [4:0] MOTIF_LENGTH_RESET = 5'd8;

    // First degenerate code; codes below it are the plain bases A, T, G, C.
    localparam logic [3:0] CODE_M = 4'd4;

    // Scores in tenths of a point.
    localparam logic [3:0] SCORE_MATCH      = 4'd10;
    localparam logic [3:0] SCORE_TRANSITION = 4'd5;
    localparam logic [3:0] SCORE_OTHER      = 4'd2;
    localparam logic [3:0] SCORE_NONE       = 4'd0;

    // Bit b is set if base b belongs to the code's set (plain codes handled apart).
    localparam logic [3:0] CODE_SET [16] = '{
        4'd1, 4'd2, 4'd4, 4'd8, 4'd9, 4'd5, 4'd3, 4'd12,
        4'd10, 4'd6, 4'd13, 4'd11, 4'd7, 4'd14, 4'd15, 4'd0
    };
    localparam logic [3:0] CODE_PTS [16] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd5, 4'd2, 4'd2,
        4'd5, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0
    };

    typedef logic [1:0] base_code_t;
    typedef logic [WIN_DEPTH-1:0][1:0] window_t;

    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
    } base_beat_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  best_score;
        logic [15:0] best_start;
        logic [31:0] best_window;
        logic        exact_match;
    } result_beat_t;

    function automatic logic [3:0] pos_score(logic [3:0] code, base_code_t b);
        logic [3:0] set_bits;
        set_bits = CODE_SET[code];
        if (code < CODE_M) begin
            if (code[1:0] == b) begin
                return SCORE_MATCH;
            end
            else if ((code[1:0] ^ b) == 2'b10) begin
                return SCORE_TRANSITION;
            end
            else begin
                return SCORE_OTHER;
            end
        end
        else if (set_bits[b]) begin
            return CODE_PTS[code];
        end
        else begin
            return SCORE_NONE;
        end
    endfunction

endpackage

FILE: rtl/core/mbws_if.sv
// Valid/ready stream interfaces for the base input and the result output.
// Depends on mbws_pkg for the beat payload types.
interface mbws_base_if
    import mbws_pkg::*;
;
    logic       valid;
    logic       ready;
    base_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mbws_result_if
    import mbws_pkg::*;
;
    logic         valid;
    logic         ready;
    result_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mbws_window_score.sv
// Scores the stored window against the motif: sixteen parallel lanes, each a
// table lookup, summed by a balanced adder tree. Depends on mbws_pkg.
module mbws_window_score
    import mbws_pkg::*;
(
    input  window_t     window,
    input  logic [63:0] motif_codes,
    input  logic [4:0]  eff_len,
    output logic [7:0]  sum,
    output logic [31:0] packed_bases
);

    logic [3:0] lane_score [WIN_DEPTH];
    logic [4:0] lvl1 [8];
    logic [5:0] lvl2 [4];
    logic [6:0] lvl3 [2];

    // Lane p compares motif position p with the base that entered len-1-p beats ago.
    always_comb
    begin
        logic [3:0] idx;
        for (int p = 0; p < WIN_DEPTH; p++)
        begin
            idx = 4'(eff_len - 5'd1 - 5'(p));
            if (5'(p) < eff_len)
            begin
                lane_score[p] = pos_score(motif_codes[4*p +: 4], window[idx]);
                packed_bases[2*p +: 2] = window[idx];
            end
            else
            begin
                lane_score[p] = SCORE_NONE;
                packed_bases[2*p +: 2] = 2'b00;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lvl1[i] = 5'(lane_score[2*i]) + 5'(lane_score[2*i+1]);
        end
        for (int i = 0; i < 4; i++)
        begin
            lvl2[i] = 6'(lvl1[2*i]) + 6'(lvl1[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl3[i] = 7'(lvl2[2*i]) + 7'(lvl2[2*i+1]);
        end
        sum = 8'(lvl3[0]) + 8'(lvl3[1]);
    end

endmodule

FILE: rtl/core/motif_best_window_scorer_core.sv
// Top level of the motif best-window scorer: window shift register, scoring
// stage, best-window tracking and the result register.
// Depends on mbws_pkg, mbws_if and mbws_window_score.
//
//   channel   direction  payload                                           beat
//   bases     in         base, last_base                                   one per base
//   result    out        found, best_score, best_start, best_window,       one per sequence
//                        exact_match
//   wr_*      in         motif_codes (index 0), motif_length (index 1)     one per write
//
// One base a cycle is taken unless a held final base closes the input; a base goes
// into the shift register, then through the scoring adder tree into the best-window
// and result registers. Reset clears the sequence state at once, but for s1_pos_reg
// and out_payload_reg; motif_codes resets to 0 and motif_length to 8. Only a final
// base waits for the result register: while a result is stalled, bases keep flowing until
// the next final base, which then holds the input closed until the result beat has gone.
module motif_best_window_scorer_core
    import mbws_pkg::*;
#(
    parameter int MAX_MOTIF_LEN = 16,
    parameter int MAX_SEQ_LEN   = 65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    mbws_base_if.sink          bases,
    mbws_result_if.source      result,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [63:0]        wr_data
);

    localparam int LEN_CAP = (MAX_MOTIF_LEN < WIN_DEPTH) ? MAX_MOTIF_LEN : WIN_DEPTH;
    localparam logic [4:0] LEN_CAP_C = 5'(LEN_CAP);
    localparam int SEEN_W = $clog2(MAX_SEQ_LEN + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_SEQ_LEN);

    // Configuration
    logic [63:0] motif_codes_reg;
    logic [4:0]  motif_length_reg;
    logic [4:0]  eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_codes_reg  <= '0;
            motif_length_reg <= MOTIF_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MOTIF_CODES:  motif_codes_reg  <= wr_data;
                REG_MOTIF_LENGTH: motif_length_reg <= wr_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (motif_length_reg == 5'd0)
        begin
            eff_len = 5'd1;
        end
        else if (motif_length_reg > LEN_CAP_C)
        begin
            eff_len = LEN_CAP_C;
        end
        else
        begin
            eff_len = motif_length_reg;
        end
    end

    // Stage one: window shift register and base count
    window_t           window_reg, window_next, window_src;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_src, seen_inc;
    logic              seq_end_reg, seq_end_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg, s1_last_next;
    logic              s1_scored_reg, s1_scored_next;
    logic [SEEN_W-1:0] s1_pos_reg, s1_pos_next;
    logic              s1_go;
    logic              in_accept;

    assign s1_go     = s1_valid_reg && (!s1_last_reg || !result.valid || result.ready);
    assign bases.ready = !s1_valid_reg || s1_go;
    assign in_accept = bases.valid && bases.ready;

    // A new sequence starts from an empty window once the previous final base has gone in.
    assign window_src = seq_end_reg ? '0 : window_reg;
    assign seen_src   = seq_end_reg ? '0 : seen_reg;
    assign seen_inc   = seen_src + SEEN_W'(1);

    always_comb
    begin
        window_next    = window_reg;
        seen_next      = seen_reg;
        seq_end_next   = seq_end_reg;
        s1_valid_next  = s1_go ? 1'b0 : s1_valid_reg;
        s1_last_next   = s1_last_reg;
        s1_scored_next = s1_scored_reg;
        s1_pos_next    = s1_pos_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = bases.payload.last_base;
            seq_end_next  = bases.payload.last_base;
            if (seen_src < SEEN_MAX)
            begin
                window_next    = {window_src[WIN_DEPTH-2:0], bases.payload.base};
                seen_next      = seen_inc;
                s1_scored_next = seen_inc >= SEEN_W'(eff_len);
                s1_pos_next    = seen_inc - SEEN_W'(eff_len);
            end
            else
            begin
                window_next    = window_src;
                seen_next      = seen_src;
                s1_scored_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            seen_reg      <= '0;
            seq_end_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_scored_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            seq_end_reg   <= seq_end_next;
            s1_valid_reg  <= s1_valid_next;
            s1_last_reg   <= s1_last_next;
            s1_scored_reg <= s1_scored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg <= s1_pos_next;
    end

    // Stage two: score, best-window tracking and the result register
    logic [7:0]        win_sum;
    logic [31:0]       win_packed;
    logic              best_valid_reg, best_valid_next, best_valid_upd;
    logic [7:0]        best_sum_reg, best_sum_next, best_sum_upd;
    logic [SEEN_W-1:0] best_pos_reg, best_pos_next, best_pos_upd;
    logic [31:0]       best_bases_reg, best_bases_next, best_bases_upd;
    logic              take_new;
    logic              out_valid_reg, out_valid_next;
    result_beat_t      out_payload_reg, out_payload_next;

    mbws_window_score u_score (
        .window       (window_reg),
        .motif_codes  (motif_codes_reg),
        .eff_len      (eff_len),
        .sum          (win_sum),
        .packed_bases (win_packed)
    );

    // Strictly greater keeps the earliest window on a tie.
    assign take_new       = s1_scored_reg && (!best_valid_reg || win_sum > best_sum_reg);
    assign best_valid_upd = best_valid_reg || take_new;
    assign best_sum_upd   = take_new ? win_sum    : best_sum_reg;
    assign best_pos_upd   = take_new ? s1_pos_reg : best_pos_reg;
    assign best_bases_upd = take_new ? win_packed : best_bases_reg;

    always_comb
    begin
        best_valid_next  = best_valid_reg;
        best_sum_next    = best_sum_reg;
        best_pos_next    = best_pos_reg;
        best_bases_next  = best_bases_reg;
        out_valid_next   = (out_valid_reg && !result.ready) ? 1'b1 : 1'b0;
        out_payload_next = out_payload_reg;
        if (s1_go)
        begin
            if (s1_last_reg)
            begin
                best_valid_next = 1'b0;
                best_sum_next   = '0;
                best_pos_next   = '0;
                best_bases_next = '0;
                out_valid_next  = 1'b1;
                if (best_valid_upd)
                begin
                    out_payload_next.found       = 1'b1;
                    out_payload_next.best_score  = best_sum_upd;
                    out_payload_next.best_start  = 16'(best_pos_upd);
                    out_payload_next.best_window = best_bases_upd;
                    out_payload_next.exact_match =
                        (best_sum_upd == 8'(eff_len) * 8'd10);
                end
                else
                begin
                    out_payload_next = '0;
                end
            end
            else
            begin
                best_valid_next = best_valid_upd;
                best_sum_next   = best_sum_upd;
                best_pos_next   = best_pos_upd;
                best_bases_next = best_bases_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_sum_reg   <= '0;
            best_pos_reg   <= '0;
            best_bases_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_valid_reg <= best_valid_next;
            best_sum_reg   <= best_sum_next;
            best_pos_reg   <= best_pos_next;
            best_bases_reg <= best_bases_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_payload_reg <= out_payload_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

`ifndef SYNTHESIS
    // A sequence without a full window reports nothing but zeros.
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.payload.found) |->
            (result.payload.best_score == 8'd0 && result.payload.best_start == 16'd0 &&
             result.payload.best_window == 32'd0 && !result.payload.exact_match))
        else $error("empty result carries non-zero fields");

    a_exact_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.exact_match) |-> result.payload.found)
        else $error("exact match reported without a window");

    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.payload.best_score <= 8'(LEN_CAP) * 8'd10))
        else $error("best score above the largest possible window sum");

    // A held final base keeps the input closed until the result register frees up.
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && result.valid && !result.ready) |-> !bases.ready)
        else $error("input open while a final base is held");
`endif

endmodule
